// ===== rtl/core/record_reader_writer_lock_table_unit_defines.svh =====
// Assertion macros shared by the lock table modules.
`ifndef RECORD_READER_WRITER_LOCK_TABLE_UNIT_DEFINES_SVH
`define RECORD_READER_WRITER_LOCK_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define RRWLT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRWLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RRWLT_ASSERT_SAME(label, clk, rst, ante, cons)
`define RRWLT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/rrwlt_pkg.sv =====
package rrwlt_pkg;

  localparam int RECORDS_DEF     = 256;
  localparam int MAX_HOLDERS_DEF = 255;

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 8;
  localparam int OFFSET_W = 32;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 8;

  localparam logic [FUNC_W-1:0] FN_REGISTER    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ACQ_READ    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ACQ_WRITE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RELEASE     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CHECK_READ  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CHECK_WRITE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WRONG = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/record_reader_writer_lock_table_unit.sv =====
// Reader/writer lock table, one entry per record.
// Request channel: func, record_id and entry_offset are taken at a rising edge where
// start is high and busy is low. busy is high in the cycle after acceptance.
// Result channel: done is high for exactly one cycle, carrying status, record_offset,
// lock_mode and holder_count; the receiver cannot stall it, so it must take the item.
// The table entry is read from the synchronous memories at the accepting edge, the next
// cycle modifies and writes it back and registers the result, and done is high in the
// cycle after that. A new item cannot be accepted while busy is high, that is until the
// previous item has been written back.
// The done cycle of one item may coincide with the acceptance of the next.
// Reset clears the controller, the done strobe and the per-record known flags, so every
// record starts unknown, free and without holders; no clearing pass is needed.
// Offsets of a record are valid only after it has been registered.
module record_reader_writer_lock_table_unit #(
  parameter int RECORDS     = rrwlt_pkg::RECORDS_DEF,
  parameter int MAX_HOLDERS = rrwlt_pkg::MAX_HOLDERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [rrwlt_pkg::FUNC_W-1:0]    func,
  input  logic [rrwlt_pkg::ID_W-1:0]      record_id,
  input  logic [rrwlt_pkg::OFFSET_W-1:0]  entry_offset,
  output logic                            done,
  output logic [rrwlt_pkg::STATUS_W-1:0]  status,
  output logic [rrwlt_pkg::OFFSET_W-1:0]  record_offset,
  output logic [rrwlt_pkg::MODE_W-1:0]    lock_mode,
  output logic [rrwlt_pkg::COUNT_W-1:0]   holder_count
);
  import rrwlt_pkg::*;

  ctrl_cmd_t cmd;

  rrwlt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  rrwlt_dp #(
    .RECORDS     (RECORDS),
    .MAX_HOLDERS (MAX_HOLDERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .record_id     (record_id),
    .entry_offset  (entry_offset),
    .done          (done),
    .status        (status),
    .record_offset (record_offset),
    .lock_mode     (lock_mode),
    .holder_count  (holder_count)
  );

endmodule

// ===== rtl/core/rrwlt_ctrl.sv =====
`include "record_reader_writer_lock_table_unit_defines.svh"

module rrwlt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output rrwlt_pkg::ctrl_cmd_t cmd
);
  import rrwlt_pkg::*;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state != S_IDLE);
  assign cmd.capture = start && (state == S_IDLE);
  assign cmd.exec    = (state == S_EXEC);

  `RRWLT_ASSERT_NEXT(a_capture_then_exec, clk, rst, cmd.capture, cmd.exec)
  `RRWLT_ASSERT_NEXT(a_exec_one_cycle, clk, rst, cmd.exec, !cmd.exec)
  `RRWLT_ASSERT_SAME(a_exec_follows_capture, clk, rst, cmd.exec, $past(cmd.capture))

endmodule

// ===== rtl/core/rrwlt_dp.sv =====
`include "record_reader_writer_lock_table_unit_defines.svh"

module rrwlt_dp #(
  parameter int RECORDS     = rrwlt_pkg::RECORDS_DEF,
  parameter int MAX_HOLDERS = rrwlt_pkg::MAX_HOLDERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rrwlt_pkg::ctrl_cmd_t                cmd,
  input  logic [rrwlt_pkg::FUNC_W-1:0]        func,
  input  logic [rrwlt_pkg::ID_W-1:0]          record_id,
  input  logic [rrwlt_pkg::OFFSET_W-1:0]      entry_offset,
  output logic                                done,
  output logic [rrwlt_pkg::STATUS_W-1:0]      status,
  output logic [rrwlt_pkg::OFFSET_W-1:0]      record_offset,
  output logic [rrwlt_pkg::MODE_W-1:0]        lock_mode,
  output logic [rrwlt_pkg::COUNT_W-1:0]       holder_count
);
  import rrwlt_pkg::*;

  // Only ids that fit the id field can ever be addressed.
  localparam int DEPTH = (RECORDS < (1 << ID_W)) ? RECORDS : (1 << ID_W);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int HOLD_W = $clog2(MAX_HOLDERS + 1);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HOLD_W-1:0] holders;
  } entry_t;

  entry_t               lock_mem [DEPTH];
  logic [OFFSET_W-1:0]  offset_mem [DEPTH];
  logic [DEPTH-1:0]     known;

  // Captured request.
  logic [FUNC_W-1:0]    func_q;
  logic [IDX_W-1:0]     idx_q;
  logic [OFFSET_W-1:0]  off_q;
  logic                 in_range_q;

  entry_t               rd_entry;
  logic [OFFSET_W-1:0]  rd_offset;

  logic                 kn;
  entry_t               cur;
  entry_t               upd;
  logic [STATUS_W-1:0]  st;
  logic                 wr_lock;
  logic                 wr_offset;
  logic                 set_known;
  logic [OFFSET_W-1:0]  offset_out;
  logic [31:0]          hold_wide;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= func;
      idx_q      <= record_id[IDX_W-1:0];
      off_q      <= entry_offset;
      in_range_q <= (32'(record_id) < RECORDS);
      rd_entry   <= lock_mem[record_id[IDX_W-1:0]];
      rd_offset  <= offset_mem[record_id[IDX_W-1:0]];
    end
  end

  // A record that is not known reads as free with no holders.
  always_comb begin
    kn = known[idx_q];
    cur.mode    = kn ? rd_entry.mode : MODE_FREE;
    cur.holders = kn ? rd_entry.holders : '0;
  end

  always_comb begin
    upd        = cur;
    st         = ST_OK;
    wr_lock    = 1'b0;
    wr_offset  = 1'b0;
    set_known  = 1'b0;
    offset_out = '0;
    if (!in_range_q) begin
      st = ST_NONE;
    end else if (func_q == FN_REGISTER) begin
      wr_offset  = 1'b1;
      wr_lock    = 1'b1;
      set_known  = 1'b1;
      offset_out = off_q;
    end else if (!kn) begin
      st = ST_NONE;
    end else begin
      unique case (func_q)
        FN_ACQ_READ: begin
          if (cur.mode == MODE_WRITE || cur.holders >= HOLD_W'(MAX_HOLDERS)) begin
            st = ST_BUSY;
          end else begin
            upd.mode    = MODE_READ;
            upd.holders = cur.holders + HOLD_W'(1);
            wr_lock     = 1'b1;
          end
        end
        FN_ACQ_WRITE: begin
          if (cur.mode != MODE_FREE) begin
            st = ST_BUSY;
          end else begin
            upd.mode    = MODE_WRITE;
            upd.holders = HOLD_W'(1);
            wr_lock     = 1'b1;
          end
        end
        FN_RELEASE: begin
          if (cur.holders == '0) begin
            st = ST_WRONG;
          end else begin
            upd.holders = cur.holders - HOLD_W'(1);
            if (upd.holders == '0) upd.mode = MODE_FREE;
            wr_lock = 1'b1;
          end
        end
        FN_CHECK_READ: begin
          if (cur.mode == MODE_FREE) st = ST_WRONG;
        end
        FN_CHECK_WRITE: begin
          if (cur.mode != MODE_WRITE) st = ST_WRONG;
        end
        default: st = ST_WRONG;
      endcase
      if (st == ST_OK) offset_out = rd_offset;
    end
  end

  assign hold_wide = 32'(upd.holders);

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_lock) lock_mem[idx_q] <= upd;
    if (cmd.exec && wr_offset) offset_mem[idx_q] <= off_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known <= '0;
    end else if (cmd.exec && set_known) begin
      known[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status        <= st;
      record_offset <= offset_out;
      if (st == ST_NONE) begin
        lock_mode    <= MODE_FREE;
        holder_count <= '0;
      end else begin
        lock_mode    <= upd.mode;
        holder_count <= (hold_wide > 32'(COUNT_MAX)) ? COUNT_MAX : hold_wide[COUNT_W-1:0];
      end
    end
  end

  `RRWLT_ASSERT_SAME(a_none_is_empty, clk, rst, done && status == ST_NONE,
                     lock_mode == MODE_FREE && holder_count == '0)
  `RRWLT_ASSERT_SAME(a_fail_no_offset, clk, rst, done && status != ST_OK, record_offset == '0)
  `RRWLT_ASSERT_SAME(a_free_no_holders, clk, rst, done && lock_mode == MODE_FREE,
                     holder_count == '0)

endmodule

// ===== verif/record_reader_writer_lock_table_unit_test.sv =====
module record_reader_writer_lock_table_unit_test;
  import rrwlt_pkg::*;

  // Function codes the block does not implement; a known record answers wrong state.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam int HOT_COUNT      = 6;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PER_RUN = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
    logic [MODE_W-1:0]   mode;
    logic [COUNT_W-1:0]  count;
  } lock_reply_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   fn;
    logic [ID_W-1:0]     id;
    logic [OFFSET_W-1:0] off;
    logic                typed;
    lock_reply_t         reply;
  } request_row_t;

  // Rows with typed set carry the answer written out by hand; the rest use the predictor.
  localparam request_row_t REQUEST_TABLE [0:24] = '{
    '{FN_ACQ_READ,    8'd0,   32'h0,        1'b1, '{ST_NONE,  32'h0,        MODE_FREE,  8'd0}},
    '{FN_RELEASE,     8'd255, 32'hFFFFFFFF, 1'b1, '{ST_NONE,  32'h0,        MODE_FREE,  8'd0}},
    '{FN_CHECK_WRITE, 8'd7,   32'h0,        1'b1, '{ST_NONE,  32'h0,        MODE_FREE,  8'd0}},
    '{FN_SPARE_7,     8'd7,   32'h0,        1'b1, '{ST_NONE,  32'h0,        MODE_FREE,  8'd0}},
    '{FN_REGISTER,    8'd0,   32'h0,        1'b1, '{ST_OK,    32'h0,        MODE_FREE,  8'd0}},
    '{FN_REGISTER,    8'd255, 32'hFFFFFFFF, 1'b1, '{ST_OK,    32'hFFFFFFFF, MODE_FREE,  8'd0}},
    '{FN_RELEASE,     8'd0,   32'h0,        1'b1, '{ST_WRONG, 32'h0,        MODE_FREE,  8'd0}},
    '{FN_CHECK_READ,  8'd0,   32'h0,        1'b1, '{ST_WRONG, 32'h0,        MODE_FREE,  8'd0}},
    '{FN_CHECK_WRITE, 8'd0,   32'h0,        1'b1, '{ST_WRONG, 32'h0,        MODE_FREE,  8'd0}},
    '{FN_ACQ_WRITE,   8'd255, 32'h0,        1'b1, '{ST_OK,    32'hFFFFFFFF, MODE_WRITE, 8'd1}},
    '{FN_ACQ_READ,    8'd255, 32'h0,        1'b1, '{ST_BUSY,  32'h0,        MODE_WRITE, 8'd1}},
    '{FN_ACQ_WRITE,   8'd255, 32'h0,        1'b1, '{ST_BUSY,  32'h0,        MODE_WRITE, 8'd1}},
    '{FN_CHECK_WRITE, 8'd255, 32'h0,        1'b1, '{ST_OK,    32'hFFFFFFFF, MODE_WRITE, 8'd1}},
    '{FN_CHECK_READ,  8'd255, 32'h0,        1'b1, '{ST_OK,    32'hFFFFFFFF, MODE_WRITE, 8'd1}},
    '{FN_REGISTER,    8'd255, 32'h5A5A5A5A, 1'b1, '{ST_OK,    32'h5A5A5A5A, MODE_WRITE, 8'd1}},
    '{FN_SPARE_6,     8'd255, 32'h0,        1'b1, '{ST_WRONG, 32'h0,        MODE_WRITE, 8'd1}},
    '{FN_SPARE_7,     8'd0,   32'hFFFFFFFF, 1'b1, '{ST_WRONG, 32'h0,        MODE_FREE,  8'd0}},
    '{FN_RELEASE,     8'd255, 32'h0,        1'b1, '{ST_OK,    32'h5A5A5A5A, MODE_FREE,  8'd0}},
    '{FN_ACQ_READ,    8'd0,   32'h0,        1'b1, '{ST_OK,    32'h0,        MODE_READ,  8'd1}},
    '{FN_ACQ_READ,    8'd0,   32'h0,        1'b1, '{ST_OK,    32'h0,        MODE_READ,  8'd2}},
    '{FN_ACQ_WRITE,   8'd0,   32'h0,        1'b1, '{ST_BUSY,  32'h0,        MODE_READ,  8'd2}},
    '{FN_CHECK_READ,  8'd0,   32'h0,        1'b0, '0},
    '{FN_CHECK_WRITE, 8'd0,   32'h0,        1'b1, '{ST_WRONG, 32'h0,        MODE_READ,  8'd2}},
    '{FN_RELEASE,     8'd0,   32'h0,        1'b0, '0},
    '{FN_REGISTER,    8'd128, 32'h80000001, 1'b0, '0}
  };

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   func;
  logic [ID_W-1:0]     record_id;
  logic [OFFSET_W-1:0] entry_offset;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] record_offset;
  logic [MODE_W-1:0]   lock_mode;
  logic [COUNT_W-1:0]  holder_count;

  // Answer typed into the table for the item now on the request ports, if any.
  logic        req_typed;
  lock_reply_t req_reply;

  // Shadow copy of the lock table.
  logic                rec_known   [256];
  logic [MODE_W-1:0]   rec_mode    [256];
  int unsigned         rec_holders [256];
  logic [OFFSET_W-1:0] rec_offset  [256];

  lock_reply_t pending_replies[$];
  logic [ID_W-1:0] hot_ids [HOT_COUNT];

  int idle_pct;
  int errors;
  int items_taken;
  int replies_seen;
  int busy_seen;
  int wrong_seen;
  int none_seen;
  int quiet_cycles;

  record_reader_writer_lock_table_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .record_id    (record_id),
    .entry_offset (entry_offset),
    .done         (done),
    .status       (status),
    .record_offset(record_offset),
    .lock_mode    (lock_mode),
    .holder_count (holder_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lock_reply_t apply_lock_request(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                                     logic [OFFSET_W-1:0] off);
    lock_reply_t r;
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    r = '{ST_NONE, '0, MODE_FREE, '0};
    if (fn == FN_REGISTER) begin
      if (!rec_known[id]) begin
        rec_known[id] = 1'b1;
        rec_mode[id] = MODE_FREE;
        rec_holders[id] = 0;
      end
      rec_offset[id] = off;
    end else if (!rec_known[id]) begin
      return r;
    end else begin
      case (fn)
        FN_ACQ_READ: begin
          if (rec_mode[id] == MODE_WRITE || rec_holders[id] >= MAX_HOLDERS_DEF) begin
            st = ST_BUSY;
          end else begin
            rec_mode[id] = MODE_READ;
            rec_holders[id]++;
          end
        end
        FN_ACQ_WRITE: begin
          if (rec_mode[id] != MODE_FREE) begin
            st = ST_BUSY;
          end else begin
            rec_mode[id] = MODE_WRITE;
            rec_holders[id] = 1;
          end
        end
        FN_RELEASE: begin
          if (rec_holders[id] == 0) begin
            st = ST_WRONG;
          end else begin
            rec_holders[id]--;
            if (rec_holders[id] == 0) rec_mode[id] = MODE_FREE;
          end
        end
        FN_CHECK_READ: begin
          if (rec_mode[id] == MODE_FREE) st = ST_WRONG;
        end
        FN_CHECK_WRITE: begin
          if (rec_mode[id] != MODE_WRITE) st = ST_WRONG;
        end
        default: st = ST_WRONG;
      endcase
    end
    r.status = st;
    r.offset = (st == ST_OK) ? rec_offset[id] : '0;
    r.mode = rec_mode[id];
    r.count = (rec_holders[id] > 255) ? COUNT_MAX : rec_holders[id][COUNT_W-1:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [OFFSET_W-1:0] want,
                                        logic [OFFSET_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk) begin : monitor
    lock_reply_t want;
    lock_reply_t pred;
    if (!rst) begin
      quiet_cycles++;
      if (done) begin
        quiet_cycles = 0;
        replies_seen++;
        if (status == ST_BUSY) busy_seen++;
        if (status == ST_WRONG) wrong_seen++;
        if (status == ST_NONE) none_seen++;
        if (pending_replies.size() == 0) begin
          $display("%0t: result with no item outstanding, got status %0d", $time, status);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          compare_field("status", OFFSET_W'(want.status), OFFSET_W'(status));
          compare_field("record_offset", want.offset, record_offset);
          compare_field("lock_mode", OFFSET_W'(want.mode), OFFSET_W'(lock_mode));
          compare_field("holder_count", OFFSET_W'(want.count), OFFSET_W'(holder_count));
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        items_taken++;
        pred = apply_lock_request(func, record_id, entry_offset);
        pending_replies.push_back(req_typed ? req_reply : pred);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("record_reader_writer_lock_table_unit_test: errors");
        $finish;
      end
    end
  end

  task automatic issue_request(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                               logic [OFFSET_W-1:0] off, logic typed, lock_reply_t reply);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    func <= fn;
    record_id <= id;
    entry_offset <= off;
    req_typed <= typed;
    req_reply <= reply;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic request(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id, logic [OFFSET_W-1:0] off);
    issue_request(fn, id, off, 1'b0, '0);
  endtask

  function automatic logic [OFFSET_W-1:0] random_offset();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  // Fresh working set of records, registered so that most traffic gets past the lookup.
  task automatic pick_hot_records();
    for (int i = 0; i < HOT_COUNT; i++) begin
      hot_ids[i] = ID_W'($urandom_range(0, 255));
      request(FN_REGISTER, hot_ids[i], random_offset());
    end
  endtask

  task automatic random_requests(int count);
    logic [FUNC_W-1:0] fn;
    logic [ID_W-1:0] id;
    int pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        fn = FUNC_W'($urandom_range(0, 7));
        id = ID_W'($urandom_range(0, 255));
      end else begin
        id = hot_ids[$urandom_range(0, HOT_COUNT - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 8) fn = FN_REGISTER;
        else if (pick < 33) fn = FN_ACQ_READ;
        else if (pick < 48) fn = FN_ACQ_WRITE;
        else if (pick < 75) fn = FN_RELEASE;
        else if (pick < 85) fn = FN_CHECK_READ;
        else if (pick < 95) fn = FN_CHECK_WRITE;
        else fn = pick[0] ? FN_SPARE_6 : FN_SPARE_7;
      end
      request(fn, id, random_offset());
    end
  endtask

  // Fill one record with readers past the holder limit, then release it once more than the limit.
  task automatic reader_flood(logic [ID_W-1:0] id);
    request(FN_REGISTER, id, random_offset());
    for (int n = 0; n < MAX_HOLDERS_DEF + 3; n++) request(FN_ACQ_READ, id, OFFSET_W'($urandom));
    request(FN_CHECK_READ, id, '0);
    request(FN_ACQ_WRITE, id, '0);
    for (int n = 0; n < MAX_HOLDERS_DEF + 1; n++) request(FN_RELEASE, id, OFFSET_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = '0;
    record_id = '0;
    entry_offset = '0;
    req_typed = 1'b0;
    req_reply = '0;
    idle_pct = 0;
    errors = 0;
    items_taken = 0;
    replies_seen = 0;
    busy_seen = 0;
    wrong_seen = 0;
    none_seen = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 256; i++) begin
      rec_known[i] = 1'b0;
      rec_mode[i] = MODE_FREE;
      rec_holders[i] = 0;
      rec_offset[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (REQUEST_TABLE[i]) begin
      issue_request(REQUEST_TABLE[i].fn, REQUEST_TABLE[i].id, REQUEST_TABLE[i].off,
                    REQUEST_TABLE[i].typed, REQUEST_TABLE[i].reply);
    end

    idle_pct = 8;
    pick_hot_records();
    random_requests(RANDOM_PER_RUN);
    wait_drained();

    idle_pct = 46;
    reader_flood(ID_W'($urandom_range(0, 255)));
    pick_hot_records();
    random_requests(RANDOM_PER_RUN / 4);

    idle_pct = 0;
    pick_hot_records();
    random_requests(RANDOM_PER_RUN);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results, including a reader flood past the limit.",
             items_taken, replies_seen);
    $display("Answers seen: %0d busy, %0d wrong state, %0d no such record; %0d mismatches.",
             busy_seen, wrong_seen, none_seen, errors);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("record_reader_writer_lock_table_unit_test: clean");
    end else begin
      $display("record_reader_writer_lock_table_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rrwlt_pkg.sv
rtl/core/rrwlt_ctrl.sv
rtl/core/rrwlt_dp.sv
rtl/core/record_reader_writer_lock_table_unit.sv
verif/record_reader_writer_lock_table_unit_test.sv
